// ===== hw/rtl/lidar_polar_to_cartesian_top_defines.svh =====
// assertion macros, used by lpc_out_buf
`ifndef LIDAR_POLAR_TO_CARTESIAN_TOP_DEFINES_SVH
`define LIDAR_POLAR_TO_CARTESIAN_TOP_DEFINES_SVH

// same-cycle implication, checked on the rising clock, off during reset
`define LPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on the rising clock, off during reset
`define LPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lpc_pkg.sv =====
package lpc_pkg;

  // field widths
  localparam int ANGLE_FIELD_W = 16;
  localparam int DIST_W        = 18;
  localparam int COORD_W       = 17;
  localparam int TDATA_IN_W    = 40;
  localparam int TDATA_OUT_W   = 40;

  // default parameter values
  localparam int ANGLE_BITS_DEF     = 16;
  localparam int TRIG_FRAC_BITS_DEF = 16;

  // threshold after reset, 30 mm in quarter millimetres
  localparam logic [DIST_W-1:0] MIN_DIST_RESET = 18'd120;

  // largest coordinate magnitude
  localparam logic [COORD_W-1:0] COORD_MAX = 17'd65535;

  // cordic datapath
  localparam int PHASE_W      = 32;
  localparam int CORDIC_W     = 32;
  localparam int CORDIC_Z_W   = 33;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_ITERS = 30;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 32'sd652032874;

  // rotation state carried from stage to stage
  typedef struct packed {
    logic [1:0]                   quad;
    logic [DIST_W-1:0]            dist_q2;
    logic signed [CORDIC_W-1:0]   x;
    logic signed [CORDIC_W-1:0]   y;
    logic signed [CORDIC_Z_W-1:0] z;
  } lpc_rot_t;

  // one result point
  typedef struct packed {
    logic signed [COORD_W-1:0] y_mm;
    logic signed [COORD_W-1:0] x_mm;
  } lpc_point_t;

  // arctangent of 2^-i, 2^32 phase units per turn
  function automatic logic signed [CORDIC_Z_W-1:0] lpc_atan(input int idx);
    logic signed [CORDIC_Z_W-1:0] a;
    a = '0;
    unique case (idx)
      0:  a = 33'sh020000000;
      1:  a = 33'sh012E4051E;
      2:  a = 33'sh009FB385B;
      3:  a = 33'sh0051111D4;
      4:  a = 33'sh0028B0D43;
      5:  a = 33'sh00145D7E1;
      6:  a = 33'sh000A2F61E;
      7:  a = 33'sh000517C55;
      8:  a = 33'sh00028BE53;
      9:  a = 33'sh000145F2F;
      10: a = 33'sh0000A2F98;
      11: a = 33'sh0000517CC;
      12: a = 33'sh000028BE6;
      13: a = 33'sh0000145F3;
      14: a = 33'sh00000A2FA;
      15: a = 33'sh00000517D;
      16: a = 33'sh0000028BE;
      17: a = 33'sh00000145F;
      18: a = 33'sh000000A30;
      19: a = 33'sh000000518;
      20: a = 33'sh00000028C;
      21: a = 33'sh000000146;
      22: a = 33'sh0000000A3;
      23: a = 33'sh000000051;
      24: a = 33'sh000000029;
      25: a = 33'sh000000014;
      26: a = 33'sh00000000A;
      27: a = 33'sh000000005;
      28: a = 33'sh000000003;
      29: a = 33'sh000000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/lidar_polar_to_cartesian_top.sv =====
// polar to cartesian conversion of range-scanner samples
// s_axis: one sample per transaction, tdata = angle_code[15:0], dist_q2[33:16]
// m_axis: one point per transaction, tdata = x_mm[16:0], y_mm[33:17], signed mm
//   x = -dist*sin(angle), y = -dist*cos(angle), truncated toward zero
// cfg: write of min_distance_q2; samples with dist_q2 at or below it give no point
//   cfg_ready_o is always high; write only while no sample is in flight
// throughput: one sample per cycle; the 30-stage cordic, one rotation per stage,
//   is followed by trig rounding, multiply and coordinate stages
// reset: all stage valids and the output clear, threshold returns to 120 (30 mm)
// stall: the output register has one skid entry behind it; when that entry fills
//   the whole pipeline and s_axis_tready_o hold until the sink takes a transaction
module lidar_polar_to_cartesian_top
  import lpc_pkg::*;
#(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // angle_code [15:0], dist_q2 [33:16], zero pad
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // x_mm [16:0], y_mm [33:17], zero pad
  output logic [TDATA_OUT_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  input  logic [DIST_W-1:0]      cfg_data_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o
);

  logic [DIST_W-1:0]        min_dist_q;
  logic [ANGLE_FIELD_W-1:0] angle;
  logic [DIST_W-1:0]        dist_in;
  logic [ANGLE_BITS-1:0]    code;
  logic [PHASE_W-1:0]       phase;
  logic                     adv;
  logic                     entry_valid;
  lpc_rot_t                 entry_rot;
  logic                     stage_valid [CORDIC_ITERS+1];
  lpc_rot_t                 stage_rot   [CORDIC_ITERS+1];
  logic                     scale_valid;
  lpc_point_t               scale_point, out_point;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= MIN_DIST_RESET;
    end else if (cfg_valid_i) begin
      min_dist_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // unpack the sample
  assign angle   = s_axis_tdata_i[ANGLE_FIELD_W-1:0];
  assign dist_in = s_axis_tdata_i[ANGLE_FIELD_W+DIST_W-1:ANGLE_FIELD_W];

  // angle code to full-turn phase
  if (ANGLE_BITS <= ANGLE_FIELD_W) begin : g_code_narrow
    assign code = angle[ANGLE_BITS-1:0];
  end else begin : g_code_wide
    assign code = {{(ANGLE_BITS-ANGLE_FIELD_W){1'b0}}, angle};
  end
  assign phase = {code, {(PHASE_W-ANGLE_BITS){1'b0}}};

  // cordic start: first-quadrant residual, gain-compensated unit vector
  always_comb begin
    entry_rot.quad    = phase[PHASE_W-1:PHASE_W-2];
    entry_rot.dist_q2 = dist_in;
    entry_rot.x       = CORDIC_GAIN_INV;
    entry_rot.y       = '0;
    entry_rot.z       = CORDIC_Z_W'(phase[PHASE_W-3:0]);
  end

  // short samples never enter as valid
  assign entry_valid     = s_axis_tvalid_i && adv && (dist_in > min_dist_q);
  assign s_axis_tready_o = adv;

  assign stage_valid[0] = entry_valid;
  assign stage_rot[0]   = entry_rot;

  // rotation stages
  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
    lpc_cordic_stage #(
      .SHIFT(i)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(stage_valid[i]),
      .data_i (stage_rot[i]),
      .valid_o(stage_valid[i+1]),
      .data_o (stage_rot[i+1])
    );
  end

  // trig rounding, multiply, coordinate
  lpc_scale #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(stage_valid[CORDIC_ITERS]),
    .rot_i  (stage_rot[CORDIC_ITERS]),
    .valid_o(scale_valid),
    .point_o(scale_point)
  );

  // output register and skid
  lpc_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(scale_valid),
    .point_i(scale_point),
    .adv_o  (adv),
    .valid_o(m_axis_tvalid_o),
    .point_o(out_point),
    .ready_i(m_axis_tready_i)
  );

  assign m_axis_tdata_o = {{(TDATA_OUT_W-2*COORD_W){1'b0}}, out_point.y_mm, out_point.x_mm};

endmodule

// ===== hw/rtl/lpc_cordic_stage.sv =====
module lpc_cordic_stage
  import lpc_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  lpc_rot_t data_i,
  output logic     valid_o,
  output lpc_rot_t data_o
);

  localparam logic signed [CORDIC_Z_W-1:0] Atan = lpc_atan(SHIFT);

  logic     valid_q;
  lpc_rot_t data_q, data_d;
  logic signed [CORDIC_W-1:0] dx, dy;

  // one micro-rotation, direction from the sign of the residual angle
  always_comb begin
    dx = data_i.y >>> SHIFT;
    dy = data_i.x >>> SHIFT;
    data_d = data_i;
    if (!data_i.z[CORDIC_Z_W-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - Atan;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + Atan;
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/lpc_scale.sv =====
module lpc_scale
  import lpc_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  lpc_rot_t   rot_i,
  output logic       valid_o,
  output lpc_point_t point_o
);

  localparam int TrigW  = TRIG_FRAC_BITS + 2;
  localparam int MagW   = TRIG_FRAC_BITS + 1;
  localparam int ProdW  = DIST_W + MagW;
  localparam int Shift  = CORDIC_FRAC - TRIG_FRAC_BITS;
  localparam logic signed [CORDIC_W:0] Rnd = (CORDIC_W+1)'(64'd1 << (Shift - 1));
  localparam logic signed [CORDIC_W:0] One = (CORDIC_W+1)'(64'd1 << TRIG_FRAC_BITS);

  // round to the trig format and clamp to plus or minus one
  function automatic logic signed [TrigW-1:0] to_trig(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W:0] s;
    logic signed [CORDIC_W:0] r;
    s = {v[CORDIC_W-1], v} + Rnd;
    r = s >>> Shift;
    if (r > One) begin
      r = One;
    end else if (r < -One) begin
      r = -One;
    end
    return r[TrigW-1:0];
  endfunction

  logic                     vt_q, vm_q, vc_q;
  logic signed [TrigW-1:0]  sin_q, cos_q, sin_d, cos_d, sr, cr;
  logic [DIST_W-1:0]        dist_t_q;
  logic [MagW-1:0]          mag_s, mag_c;
  logic [ProdW-1:0]         prod_x_q, prod_y_q;
  logic                     pos_x_q, pos_y_q;
  logic [COORD_W-1:0]       m_x, m_y, c_x, c_y;
  lpc_point_t               point_q, point_d;

  // quadrant folding of the first-quadrant result
  always_comb begin
    sr = to_trig(rot_i.y);
    cr = to_trig(rot_i.x);
    sin_d = sr;
    cos_d = cr;
    unique case (rot_i.quad)
      2'd0: begin sin_d = sr;  cos_d = cr;  end
      2'd1: begin sin_d = cr;  cos_d = -sr; end
      2'd2: begin sin_d = -sr; cos_d = -cr; end
      2'd3: begin sin_d = -cr; cos_d = sr;  end
      default: begin sin_d = sr; cos_d = cr; end
    endcase
  end

  // magnitudes for the multipliers
  always_comb begin
    mag_s = sin_q[TrigW-1] ? MagW'(-sin_q) : MagW'(sin_q);
    mag_c = cos_q[TrigW-1] ? MagW'(-cos_q) : MagW'(cos_q);
  end

  // drop fraction and quarter bits, saturate, apply sign
  always_comb begin
    m_x = prod_x_q[ProdW-1:TRIG_FRAC_BITS+2];
    m_y = prod_y_q[ProdW-1:TRIG_FRAC_BITS+2];
    c_x = (m_x > COORD_MAX) ? COORD_MAX : m_x;
    c_y = (m_y > COORD_MAX) ? COORD_MAX : m_y;
    point_d.x_mm = pos_x_q ? -c_x : c_x;
    point_d.y_mm = pos_y_q ? -c_y : c_y;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= 1'b0;
      vm_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      vt_q <= valid_i;
      vm_q <= vt_q;
      vc_q <= vm_q;
    end
  end

  // stage payloads: trig, product, coordinate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q    <= sin_d;
      cos_q    <= cos_d;
      dist_t_q <= rot_i.dist_q2;
      prod_x_q <= {{MagW{1'b0}}, dist_t_q} * {{DIST_W{1'b0}}, mag_s};
      prod_y_q <= {{MagW{1'b0}}, dist_t_q} * {{DIST_W{1'b0}}, mag_c};
      pos_x_q  <= !sin_q[TrigW-1] && (sin_q != '0);
      pos_y_q  <= !cos_q[TrigW-1] && (cos_q != '0);
      point_q  <= point_d;
    end
  end

  assign valid_o = vc_q;
  assign point_o = point_q;

endmodule

// ===== hw/rtl/lpc_out_buf.sv =====
`include "lidar_polar_to_cartesian_top_defines.svh"

module lpc_out_buf
  import lpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  lpc_point_t point_i,
  output logic       adv_o,
  output logic       valid_o,
  output lpc_point_t point_o,
  input  logic       ready_i
);

  logic       out_valid_q, out_valid_d;
  logic       skid_full_q, skid_full_d;
  lpc_point_t out_q, out_d, skid_q, skid_d;

  // output register plus one skid entry; the pipeline holds while the skid is full
  always_comb begin
    out_valid_d = out_valid_q;
    skid_full_d = skid_full_q;
    out_d       = out_q;
    skid_d      = skid_q;
    if (skid_full_q) begin
      if (ready_i) begin
        out_d       = skid_q;
        out_valid_d = 1'b1;
        skid_full_d = 1'b0;
      end
    end else if (!out_valid_q || ready_i) begin
      out_d       = point_i;
      out_valid_d = valid_i;
    end else if (valid_i) begin
      skid_d      = point_i;
      skid_full_d = 1'b1;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_full_q <= skid_full_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign adv_o   = !skid_full_q;
  assign valid_o = out_valid_q;
  assign point_o = out_q;

  // skid entry only exists behind a waiting output
  `LPC_ASSERT_NOW(a_skid_behind_out, skid_full_q, out_valid_q, "skid full with empty output")
  // a stalled skid entry is kept
  `LPC_ASSERT_NEXT(a_skid_held, skid_full_q && !ready_i, skid_full_q && $stable(skid_q),
    "skid entry lost under stall")
  // skid drains on the first taken transaction
  `LPC_ASSERT_NEXT(a_skid_drain, skid_full_q && ready_i, !skid_full_q && out_valid_q,
    "skid did not drain")

endmodule

// ===== test/tb_lidar_polar_to_cartesian_top.sv =====
`timescale 1ns / 1ps

import lpc_pkg::*;

// expected points for accepted samples, checked in order of arrival
class point_scoreboard;
  lpc_point_t        pending_q[$];
  logic [DIST_W-1:0] min_dist_q2;
  int unsigned       mismatches;
  int unsigned       samples;
  int unsigned       dropped;
  int unsigned       points;
  int unsigned       thr_writes;

  function new();
    min_dist_q2 = MIN_DIST_RESET;
    mismatches  = 0;
    samples     = 0;
    dropped     = 0;
    points      = 0;
    thr_writes  = 0;
  endfunction

  // rotation angle of step idx, 2^32 phase units per turn
  function longint atan_phase(int idx);
    case (idx)
      0:  return 64'h20000000;
      1:  return 64'h12E4051E;
      2:  return 64'h09FB385B;
      3:  return 64'h051111D4;
      4:  return 64'h028B0D43;
      5:  return 64'h0145D7E1;
      6:  return 64'h00A2F61E;
      7:  return 64'h00517C55;
      8:  return 64'h0028BE53;
      9:  return 64'h00145F2F;
      10: return 64'h000A2F98;
      11: return 64'h000517CC;
      12: return 64'h00028BE6;
      13: return 64'h000145F3;
      14: return 64'h0000A2FA;
      15: return 64'h0000517D;
      16: return 64'h000028BE;
      17: return 64'h0000145F;
      18: return 64'h00000A30;
      19: return 64'h00000518;
      20: return 64'h0000028C;
      21: return 64'h00000146;
      22: return 64'h000000A3;
      23: return 64'h00000051;
      24: return 64'h00000029;
      25: return 64'h00000014;
      26: return 64'h0000000A;
      27: return 64'h00000005;
      28: return 64'h00000003;
      29: return 64'h00000001;
      default: return 64'h0;
    endcase
  endfunction

  // round the cordic output to trig precision and clamp to +-1.0
  function longint round_trig(longint v);
    longint one;
    longint r;
    one = longint'(1) << TRIG_FRAC_BITS_DEF;
    r = (v + (longint'(1) << (CORDIC_FRAC - TRIG_FRAC_BITS_DEF - 1)))
        >>> (CORDIC_FRAC - TRIG_FRAC_BITS_DEF);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r;
  endfunction

  // first-quadrant rotation, then quadrant fold from the top phase bits
  function void sin_cos(input logic [PHASE_W-1:0] phase, output longint sin_q,
                        output longint cos_q);
    logic [1:0] quad;
    longint     x, y, z, dx, dy, sr, cr;
    quad = phase[PHASE_W-1 -: 2];
    z    = longint'(phase[CORDIC_FRAC-1:0]);
    x    = longint'(CORDIC_GAIN_INV);
    y    = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_phase(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_phase(i);
      end
    end
    sr = round_trig(y);
    cr = round_trig(x);
    case (quad)
      2'd0: begin sin_q = sr;  cos_q = cr;  end
      2'd1: begin sin_q = cr;  cos_q = -sr; end
      2'd2: begin sin_q = -sr; cos_q = -cr; end
      default: begin sin_q = -cr; cos_q = sr; end
    endcase
  endfunction

  // -dist * trig in mm, truncated toward zero, magnitude capped
  function logic signed [COORD_W-1:0] scale_coord(longint dist_q2, longint trig);
    longint mag;
    longint m;
    mag = (trig < 0) ? -trig : trig;
    m = (dist_q2 * mag) >>> (TRIG_FRAC_BITS_DEF + 2);
    if (m > 65535) m = 65535;
    if (trig > 0) m = -m;
    return m[COORD_W-1:0];
  endfunction

  // accepted sample: drop it or queue the point it should produce
  function void note_sample(logic [ANGLE_FIELD_W-1:0] angle_code,
                            logic [DIST_W-1:0] dist_q2);
    longint                code;
    longint                s, c;
    logic [PHASE_W-1:0]    phase;
    lpc_point_t            p;
    samples++;
    if (dist_q2 <= min_dist_q2) begin
      dropped++;
      return;
    end
    code  = longint'(angle_code) & ((longint'(1) << ANGLE_BITS_DEF) - 1);
    phase = PHASE_W'(code << (PHASE_W - ANGLE_BITS_DEF));
    sin_cos(phase, s, c);
    p.x_mm = scale_coord(longint'(dist_q2), s);
    p.y_mm = scale_coord(longint'(dist_q2), c);
    pending_q.push_back(p);
  endfunction

  task report(string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch: %s", msg);
  endtask

  // compare one output transaction with the oldest pending point
  task check_point(logic [TDATA_OUT_W-1:0] tdata);
    lpc_point_t got;
    lpc_point_t want;
    got = lpc_point_t'(tdata[2*COORD_W-1:0]);
    points++;
    if (pending_q.size() == 0) begin
      report($sformatf("point %0d (x %0d, y %0d) with no sample pending",
                       points, got.x_mm, got.y_mm));
      return;
    end
    want = pending_q.pop_front();
    if (got.x_mm !== want.x_mm)
      report($sformatf("point %0d x_mm got %0d want %0d", points, got.x_mm, want.x_mm));
    if (got.y_mm !== want.y_mm)
      report($sformatf("point %0d y_mm got %0d want %0d", points, got.y_mm, want.y_mm));
  endtask

  task check_empty();
    if (pending_q.size() != 0)
      report($sformatf("%0d points never arrived", pending_q.size()));
  endtask
endclass

module tb_lidar_polar_to_cartesian_top;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DIST_TOP     = 262143;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic [TDATA_IN_W-1:0]  s_axis_tdata_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [TDATA_OUT_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [DIST_W-1:0]      cfg_data_i;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;

  point_scoreboard sb;
  int              burst_left  = 0;
  int              ready_mode  = 0;
  int              ready_timer = 0;
  int              cycle_count = 0;

  lidar_polar_to_cartesian_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // sink readiness: always ready, random, periodic, or long runs
  always @(posedge clk_i) begin
    if (ready_timer == 0) begin
      ready_mode  <= $urandom_range(0, 3);
      ready_timer <= $urandom_range(20, 300);
    end else begin
      ready_timer <= ready_timer - 1;
    end
    case (ready_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready_i <= (ready_timer[1:0] == 2'b00);
      default: m_axis_tready_i <= ($urandom_range(0, 15) == 0) ? ~m_axis_tready_i
                                                                 : m_axis_tready_i;
    endcase
  end

  // transaction monitor on all three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        sb.min_dist_q2 = cfg_data_i;
        sb.thr_writes++;
      end
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_sample(s_axis_tdata_i[ANGLE_FIELD_W-1:0],
                       s_axis_tdata_i[ANGLE_FIELD_W +: DIST_W]);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_point(m_axis_tdata_o);
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("tb_lidar_polar_to_cartesian_top: errors");
    $finish;
  end

  // one sample, then either stay in the burst or idle and pick a new burst length
  task automatic send_sample(input int angle, input int dist_q2);
    s_axis_tdata_i  <= {{(TDATA_IN_W - ANGLE_FIELD_W - DIST_W){1'b0}},
                        DIST_W'(dist_q2), ANGLE_FIELD_W'(angle)};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 30);
    end
  endtask

  // hold off until every point is out, then let dropped samples clear
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input int value);
    cfg_data_i  <= DIST_W'(value);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly uniform, with weight on the threshold edge, short range, top and powers of two
  function automatic int pick_dist(input int thr);
    int d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: d = $urandom_range(0, DIST_TOP);
      5, 6: d = thr + int'($urandom_range(0, 4)) - 2;
      7: d = $urandom_range(0, 1023);
      8: d = DIST_TOP - int'($urandom_range(0, 15));
      default: d = 1 << $urandom_range(0, DIST_W - 1);
    endcase
    if (d < 0) d = 0;
    if (d > DIST_TOP) d = DIST_TOP;
    return d;
  endfunction

  // uniform angles, some placed around the quadrant boundaries
  function automatic int pick_angle();
    int a;
    if ($urandom_range(0, 9) < 7) begin
      a = $urandom_range(0, 65535);
    end else begin
      a = int'($urandom_range(0, 3)) * 16384 + int'($urandom_range(0, 4)) - 2;
      a = a & 16'hFFFF;
    end
    return a;
  endfunction

  initial begin
    int thr_plan[7];
    int count_plan[7];
    sb = new();
    rst_ni          <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tvalid_i <= 1'b0;
    cfg_data_i      <= '0;
    cfg_valid_i     <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold: boundary distances, quadrant edges, full range
    send_sample(0, 121);
    send_sample(0, 120);
    send_sample(0, 0);
    send_sample(0, DIST_TOP);
    send_sample(16384, DIST_TOP);
    send_sample(32768, DIST_TOP);
    send_sample(49152, DIST_TOP);
    send_sample(65535, DIST_TOP);
    send_sample(8192, DIST_TOP);
    send_sample(1, DIST_TOP);
    send_sample(16383, 200000);
    send_sample(16385, 200000);
    send_sample(32767, 150000);
    send_sample(32769, 150000);
    send_sample(49151, 100000);
    send_sample(49153, 100000);
    send_sample(16'h5555, 18'h2AAAA);
    send_sample(16'hAAAA, 18'h15555);
    send_sample(24576, 119);
    wait_drained();

    // zero threshold drops only zero distance
    write_threshold(0);
    send_sample(40000, 0);
    send_sample(40000, 1);
    wait_drained();

    // top threshold drops everything
    write_threshold(DIST_TOP);
    send_sample(12345, DIST_TOP);
    send_sample(0, 0);
    wait_drained();

    // one below top passes only the saturated distance
    write_threshold(DIST_TOP - 1);
    send_sample(777, DIST_TOP);
    send_sample(777, DIST_TOP - 1);
    wait_drained();

    // random phases under several thresholds
    thr_plan   = '{0, 120, 0, DIST_TOP, 1000, 0, 0};
    thr_plan[2] = $urandom_range(0, 4095);
    thr_plan[5] = $urandom_range(0, DIST_TOP);
    count_plan = '{270, 270, 270, 60, 270, 270, 270};
    for (int ph = 0; ph < 7; ph++) begin
      write_threshold(thr_plan[ph]);
      for (int n = 0; n < count_plan[ph]; n++) begin
        send_sample(pick_angle(), pick_dist(thr_plan[ph]));
        // mid-phase pause until the pipeline is empty
        if (ph == 1 && n == count_plan[ph] / 2) wait_drained();
      end
      wait_drained();
    end

    sb.check_empty();
    $display("covered %0d samples (%0d dropped) across %0d threshold writes",
             sb.samples, sb.dropped, sb.thr_writes);
    $display("compared %0d points, %0d mismatches", sb.points, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb_lidar_polar_to_cartesian_top: clean");
    end else begin
      $display("tb_lidar_polar_to_cartesian_top: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lpc_pkg.sv
hw/rtl/lpc_cordic_stage.sv
hw/rtl/lpc_scale.sv
hw/rtl/lpc_out_buf.sv
hw/rtl/lidar_polar_to_cartesian_top.sv
test/tb_lidar_polar_to_cartesian_top.sv
